// ===== rtl/core/scancode_set1_decoder_fifo_assert.svh =====
// Assertion macros for the scan-code set 1 decoder FIFO.
// Used by the RTL files that check their own logic; no other dependencies.
// In synthesis every macro expands to nothing.
`ifndef SCANCODE_SET1_DECODER_FIFO_ASSERT_SVH
`define SCANCODE_SET1_DECODER_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
`define SC1D_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sc1d assertion failed: same-cycle check");
`define SC1D_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sc1d assertion failed: next-cycle check");
`else
`define SC1D_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SC1D_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/sc1d_pkg.sv =====
// Shared types, scan codes and the US character table for the set 1 decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sc1d_pkg;

   // operation field
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // register indexes on the csr port
   localparam logic [1:0] REG_UP_CODE    = 2'd0;
   localparam logic [1:0] REG_DOWN_CODE  = 2'd1;
   localparam logic [1:0] REG_LEFT_CODE  = 2'd2;
   localparam logic [1:0] REG_RIGHT_CODE = 2'd3;

   localparam logic [7:0] UP_CODE_RESET    = 8'd128;
   localparam logic [7:0] DOWN_CODE_RESET  = 8'd129;
   localparam logic [7:0] LEFT_CODE_RESET  = 8'd130;
   localparam logic [7:0] RIGHT_CODE_RESET = 8'd131;

   // set 1 scan codes
   localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
   localparam logic [7:0] SC_KP7        = 8'h47;
   localparam logic [7:0] SC_KP8_UP     = 8'h48;
   localparam logic [7:0] SC_KP9        = 8'h49;
   localparam logic [7:0] SC_KP4_LEFT   = 8'h4B;
   localparam logic [7:0] SC_KP5        = 8'h4C;
   localparam logic [7:0] SC_KP6_RIGHT  = 8'h4D;
   localparam logic [7:0] SC_KP1        = 8'h4F;
   localparam logic [7:0] SC_KP2_DOWN   = 8'h50;
   localparam logic [7:0] SC_KP3        = 8'h51;
   localparam logic [7:0] SC_KP0        = 8'h52;
   localparam logic [7:0] SC_TABLE_SIZE = 8'd58;

   typedef struct packed {
      logic [7:0] up;
      logic [7:0] down;
      logic [7:0] left;
      logic [7:0] right;
   } arrow_codes_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
   } push_type;

   // US layout, codes 0..57; zero means no character
   function automatic logic [7:0] us_char(input logic [5:0] code);
      logic [7:0] ch;
      case (code)
         6'd2:  ch = 8'h31;  6'd3:  ch = 8'h32;  6'd4:  ch = 8'h33;
         6'd5:  ch = 8'h34;  6'd6:  ch = 8'h35;  6'd7:  ch = 8'h36;
         6'd8:  ch = 8'h37;  6'd9:  ch = 8'h38;  6'd10: ch = 8'h39;
         6'd11: ch = 8'h30;  6'd12: ch = 8'h2D;  6'd13: ch = 8'h3D;
         6'd14: ch = 8'd8;   6'd15: ch = 8'd9;   6'd16: ch = 8'h71;
         6'd17: ch = 8'h77;  6'd18: ch = 8'h65;  6'd19: ch = 8'h72;
         6'd20: ch = 8'h74;  6'd21: ch = 8'h79;  6'd22: ch = 8'h75;
         6'd23: ch = 8'h69;  6'd24: ch = 8'h6F;  6'd25: ch = 8'h70;
         6'd26: ch = 8'h5B;  6'd27: ch = 8'h5D;  6'd28: ch = 8'd10;
         6'd30: ch = 8'h61;  6'd31: ch = 8'h73;  6'd32: ch = 8'h64;
         6'd33: ch = 8'h66;  6'd34: ch = 8'h67;  6'd35: ch = 8'h68;
         6'd36: ch = 8'h6A;  6'd37: ch = 8'h6B;  6'd38: ch = 8'h6C;
         6'd39: ch = 8'h3B;  6'd40: ch = 8'd39;  6'd41: ch = 8'h60;
         6'd43: ch = 8'd92;  6'd44: ch = 8'h7A;  6'd45: ch = 8'h78;
         6'd46: ch = 8'h63;  6'd47: ch = 8'h76;  6'd48: ch = 8'h62;
         6'd49: ch = 8'h6E;  6'd50: ch = 8'h6D;  6'd51: ch = 8'h2C;
         6'd52: ch = 8'h2E;  6'd53: ch = 8'h2F;  6'd55: ch = 8'h2A;
         6'd57: ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/core/sc1d_decode.sv =====
// Scan byte decoder: extended-prefix flag, arrow, keypad and table lookup.
// Depends on sc1d_pkg.
`timescale 1ns / 1ps

module sc1d_decode import sc1d_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_valid,
   input  logic [7:0]      scan_byte,
   input  arrow_codes_type arrow_codes,
   output push_type        push
);

   logic ext_ff;
   logic ext_in;
   logic [7:0] table_ch;

   assign table_ch = us_char(scan_byte[5:0]);

   always_comb begin
      push = '0;
      if (scan_byte == SC_EXT_PREFIX) begin
         push = '0;
      end else if (ext_ff) begin
         unique case (scan_byte)
            SC_KP8_UP:    push = '{valid: 1'b1, ch: arrow_codes.up};
            SC_KP2_DOWN:  push = '{valid: 1'b1, ch: arrow_codes.down};
            SC_KP4_LEFT:  push = '{valid: 1'b1, ch: arrow_codes.left};
            SC_KP6_RIGHT: push = '{valid: 1'b1, ch: arrow_codes.right};
            default:      push = '0;
         endcase
      end else if (!scan_byte[7]) begin
         unique case (scan_byte)
            SC_KP7:       push = '{valid: 1'b1, ch: 8'h37};
            SC_KP8_UP:    push = '{valid: 1'b1, ch: 8'h38};
            SC_KP9:       push = '{valid: 1'b1, ch: 8'h39};
            SC_KP4_LEFT:  push = '{valid: 1'b1, ch: 8'h34};
            SC_KP5:       push = '{valid: 1'b1, ch: 8'h35};
            SC_KP6_RIGHT: push = '{valid: 1'b1, ch: 8'h36};
            SC_KP1:       push = '{valid: 1'b1, ch: 8'h31};
            SC_KP2_DOWN:  push = '{valid: 1'b1, ch: 8'h32};
            SC_KP3:       push = '{valid: 1'b1, ch: 8'h33};
            SC_KP0:       push = '{valid: 1'b1, ch: 8'h30};
            default: begin
               push.valid = (scan_byte < SC_TABLE_SIZE) && (table_ch != 8'h00);
               push.ch    = table_ch;
            end
         endcase
      end
      push.valid = push.valid && byte_valid;
   end

   // any byte other than the prefix clears the flag
   assign ext_in = byte_valid ? (scan_byte == SC_EXT_PREFIX) : ext_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff <= 1'b0;
      end else begin
         ext_ff <= ext_in;
      end
   end

endmodule

// ===== rtl/core/sc1d_queue.sv =====
// Character ring FIFO holding QUEUE_DEPTH-1 entries, registered read port.
// Depends on sc1d_pkg and scancode_set1_decoder_fifo_assert.svh.
`timescale 1ns / 1ps
`include "scancode_set1_decoder_fifo_assert.svh"

module sc1d_queue import sc1d_pkg::*; #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output logic [7:0] pop_data,
   output logic       pop_empty
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

   logic [7:0]    mem [QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_next, rd_next;
   logic          full, empty, do_write;
   logic [7:0]    data_ff;
   logic          empty_ff;

   assign wr_next  = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next  = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
   assign full     = (wr_next == rd_ptr_ff);
   assign empty    = (rd_ptr_ff == wr_ptr_ff);
   assign do_write = push.valid && !full;   // drop the character when full

   assign wr_ptr_in = do_write ? wr_next : wr_ptr_ff;
   assign rd_ptr_in = (pop && !empty) ? rd_next : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_ptr_ff] <= push.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff  <= mem[rd_ptr_ff];
         empty_ff <= empty;
      end
   end

   assign pop_data  = empty_ff ? 8'h00 : data_ff;
   assign pop_empty = empty_ff;

   `SC1D_ASSERT_NOW(a_ptr_range, clock, reset, 1'b1, (wr_ptr_ff <= LAST_IDX) && (rd_ptr_ff <= LAST_IDX))
   `SC1D_ASSERT_NEXT(a_full_drop, clock, reset, push.valid && full, $stable(wr_ptr_ff))
   `SC1D_ASSERT_NEXT(a_empty_pop, clock, reset, pop && empty, empty_ff && $stable(rd_ptr_ff))

endmodule

// ===== rtl/core/scancode_set1_decoder_fifo.sv =====
// Top level of the scan-code set 1 decoder with character FIFO.
// Depends on sc1d_pkg, sc1d_decode, sc1d_queue and the assertion header.
`timescale 1ns / 1ps
`include "scancode_set1_decoder_fifo_assert.svh"

// Takes one word per cycle on the req_ channel while no pop stalls: either a
// raw set 1 scan byte (operation 0) or a pop (operation 1). A word sits in the
// input register, where the byte is decoded and written to the FIFO memory, or
// the pop reads the oldest entry; a pop answer appears on rsp_ in the next
// cycle and is held in the output register until taken. Scan bytes keep
// flowing while a pop answer waits on rsp_; a pop behind a waiting answer
// holds in the input register until rsp_ready. The FIFO keeps QUEUE_DEPTH-1
// characters and drops new ones when full; a pop on an empty FIFO answers
// character 0 with queue_empty set. Arrow-key codes are csr registers 0..3
// (up, down, left, right); the user must write them only while the block is
// idle, which the block does not enforce. No clearing pass after reset.
module scancode_set1_decoder_fifo import sc1d_pkg::*; #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_character,
   output logic       rsp_queue_empty,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   arrow_codes_type codes_ff, codes_in;
   logic            in_valid_ff, in_valid_in;
   logic            in_op_ff;
   logic [7:0]      in_byte_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            fire, pop_fire, byte_fire;
   push_type        push;

   // configuration registers
   always_comb begin
      codes_in = codes_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_UP_CODE:    codes_in.up    = csr_write_data;
            REG_DOWN_CODE:  codes_in.down  = csr_write_data;
            REG_LEFT_CODE:  codes_in.left  = csr_write_data;
            REG_RIGHT_CODE: codes_in.right = csr_write_data;
            default:        codes_in       = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= '{up: UP_CODE_RESET, down: DOWN_CODE_RESET,
                       left: LEFT_CODE_RESET, right: RIGHT_CODE_RESET};
      end else begin
         codes_ff <= codes_in;
      end
   end

   // input stage: a pop advances only when the output register is free
   assign fire      = in_valid_ff && ((in_op_ff == OP_SCAN) || !rsp_valid_ff || rsp_ready);
   assign pop_fire  = fire && (in_op_ff == OP_POP);
   assign byte_fire = fire && (in_op_ff == OP_SCAN);
   assign req_ready = !in_valid_ff || fire;

   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the payload while the stage is stalled
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_scan_byte;
      end
   end

   sc1d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (byte_fire),
      .scan_byte   (in_byte_ff),
      .arrow_codes (codes_ff),
      .push        (push)
   );

   sc1d_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop_fire),
      .pop_data  (rsp_character),
      .pop_empty (rsp_queue_empty)
   );

   // output register valid: set by a pop, drop once taken
   assign rsp_valid_in = pop_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SC1D_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !pop_fire)
   `SC1D_ASSERT_NEXT(a_pop_answers, clock, reset, pop_fire, rsp_valid_ff)
   `SC1D_ASSERT_NOW(a_one_kind, clock, reset, 1'b1, !(pop_fire && byte_fire))

endmodule
